>>> rtl/core/spq_pkg.sv
`timescale 1ns / 1ps
package spq_pkg;

  typedef enum logic [2:0] {
    MODE_ENQUEUE   = 3'd0,
    MODE_POP_FRONT = 3'd1,
    MODE_POP_EXACT = 3'd2,
    MODE_POP_MIN   = 3'd3,
    MODE_CLEAR     = 3'd4
  } mode_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_INS   = 5'b00010,
    ST_FIND  = 5'b00100,
    ST_SHIFT = 5'b01000,
    ST_HOLD  = 5'b10000
  } state_t;

  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 112;
  localparam int unsigned ID_W       = 32;
  localparam int unsigned PRIO_W     = 8;
  localparam int unsigned FIELD_PAY_W = 64;
  localparam int unsigned COUNT_W    = 5;

endpackage

>>> rtl/core/stable_priority_queue.sv
`timescale 1ns / 1ps
// channel   dir  tdata (low bit first)                              tuser
// s_*       in   priority_req[7:0], payload[71:8]                   mode[2:0]
// m_*       out  out_id[31:0], out_priority[39:32],                 ok[0]
//                out_payload[103:40], count[108:104], is_empty[109]
// entries sit in one sync ram (one read, one write port), sorted head first.
// enqueue: entries of lower priority are moved back one slot, then the new entry is
// written into the gap. pops scan from the head for a match, then move the entries
// behind it forward; clear and refused operations go straight to the result. one item is
// in work at a time and s_tready returns as the result is loaded into the output register;
// the ram's single read port, one entry per cycle, sets the pace of each step.
// rst empties the queue and sets the next id to 1; the ram is not cleared.
// a stalled result holds in the output register while the next item is taken in.
module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY     = 16,
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // priority_req, payload
  input  logic [2:0]            s_tuser,   // mode
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // out_id, out_priority, out_payload, count, is_empty
  output logic [0:0]            m_tuser    // ok
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef struct packed {
    logic [PRIO_W-1:0]       prio;
    logic [ID_W-1:0]         id;
    logic [PAYLOAD_BITS-1:0] pay;
  } entry_t;

  entry_t mem [CAPACITY];
  entry_t rd_data;
  entry_t wr_data;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;

  state_t state;
  mode_t  mode_r;
  logic [PRIO_W-1:0]       prio_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic [CW-1:0]           fill;
  logic [CW-1:0]           idx;
  logic [ID_W-1:0]         next_id;

  logic                    res_ok;
  logic [ID_W-1:0]         res_id;
  logic [PRIO_W-1:0]       res_prio;
  logic [PAYLOAD_BITS-1:0] res_pay;

  logic [CW-1:0] fill_m1;
  logic [CW:0]   idx_p1;
  logic [CW:0]   idx_p2;
  logic [CW-1:0] idx_m1;
  logic [CW-1:0] idx_m2;
  logic          accept;
  logic          out_free;
  logic          find_hit;
  logic          find_stop;
  logic          at_last;
  mode_t         in_mode;
  logic [CW+4:0] count_ext;
  entry_t        new_entry;

  assign fill_m1   = fill - 1'b1;
  assign idx_p1    = {1'b0, idx} + 1'b1;
  assign idx_p2    = {1'b0, idx} + 2'd2;
  assign idx_m1    = idx - 1'b1;
  assign idx_m2    = idx - 2'd2;
  assign in_mode   = mode_t'(s_tuser);
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign at_last   = (idx_p1 == {1'b0, fill});
  assign new_entry = '{prio: prio_r, id: next_id, pay: pay_r};
  assign count_ext = {5'd0, fill};

  always_comb begin
    unique case (mode_r)
      MODE_POP_EXACT: begin
        find_hit  = (rd_data.prio == prio_r);
        find_stop = (rd_data.prio < prio_r) || at_last;
      end
      MODE_POP_MIN: begin
        find_hit  = (rd_data.prio >= prio_r);
        find_stop = 1'b1;
      end
      default: begin
        find_hit  = 1'b1;
        find_stop = 1'b1;
      end
    endcase
  end

  // ram port control
  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = idx[AW-1:0];
    wr_data = new_entry;
    unique case (state)
      ST_IDLE: begin
        rd_addr = (in_mode == MODE_ENQUEUE) ? fill_m1[AW-1:0] : '0;
      end
      ST_INS: begin
        rd_addr = idx_m2[AW-1:0];
        wr_en   = 1'b1;
        if (idx != '0 && rd_data.prio < prio_r) begin
          wr_data = rd_data;
        end
      end
      ST_FIND: begin
        rd_addr = idx_p1[AW-1:0];
      end
      ST_SHIFT: begin
        rd_addr = idx_p2[AW-1:0];
        wr_data = rd_data;
        wr_en   = !at_last;
      end
      ST_HOLD: begin
        rd_addr = '0;
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      fill     <= '0;
      next_id  <= 32'd1;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_HOLD) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            mode_r   <= in_mode;
            prio_r   <= s_tdata[PRIO_W-1:0];
            pay_r    <= s_tdata[PRIO_W +: PAYLOAD_BITS];
            res_id   <= '0;
            res_prio <= '0;
            res_pay  <= '0;
            unique case (in_mode)
              MODE_ENQUEUE: begin
                res_ok <= 1'b0;
                if (fill != CW'(CAPACITY)) begin
                  idx   <= fill;
                  state <= ST_INS;
                end else begin
                  idx   <= '0;
                  state <= ST_HOLD;
                end
              end
              MODE_POP_FRONT, MODE_POP_EXACT, MODE_POP_MIN: begin
                res_ok <= 1'b0;
                idx    <= '0;
                state  <= (fill != '0) ? ST_FIND : ST_HOLD;
              end
              MODE_CLEAR: begin
                fill   <= '0;
                res_ok <= 1'b1;
                idx    <= '0;
                state  <= ST_HOLD;
              end
              default: begin
                res_ok <= 1'b0;
                idx    <= '0;
                state  <= ST_HOLD;
              end
            endcase
          end
        end
        ST_INS: begin
          // move lower-priority entries back one slot until the gap is in place
          if (idx != '0 && rd_data.prio < prio_r) begin
            idx <= idx_m1;
          end else begin
            fill     <= fill + 1'b1;
            next_id  <= next_id + 1'b1;
            res_ok   <= 1'b1;
            res_id   <= next_id;
            res_prio <= prio_r;
            res_pay  <= pay_r;
            state    <= ST_HOLD;
          end
        end
        ST_FIND: begin
          if (find_hit) begin
            res_ok   <= 1'b1;
            res_id   <= rd_data.id;
            res_prio <= rd_data.prio;
            res_pay  <= rd_data.pay;
            state    <= ST_SHIFT;
          end else if (find_stop) begin
            state <= ST_HOLD;
          end else begin
            idx <= idx_p1[CW-1:0];
          end
        end
        ST_SHIFT: begin
          // close the hole, one entry forward per cycle
          if (at_last) begin
            fill  <= fill_m1;
            state <= ST_HOLD;
          end else begin
            idx <= idx_p1[CW-1:0];
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            m_tuser[0] <= res_ok;
            m_tdata    <= {2'b00, (fill == '0), count_ext[COUNT_W-1:0],
                           FIELD_PAY_W'(res_pay), res_prio, res_id};
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
